// ===== sv/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg
// Types and constants shared by the sorted value list modules.
// ----------------------------------------------------------------------------
package svl_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_READOUT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_ELEMENT   = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_READOUT
   } state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_INSERT,
      DP_DELETE,
      DP_EMPTY,
      DP_ELEMENT
   } dp_op_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [VAL_W-1:0] item_value;
      logic                    last;
      logic [6:0]              entry_total;
   } rsp_type;

   typedef struct packed {
      dp_op_type op;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } dp_stat_type;

endpackage

// ===== sv/svl_ctrl.sv =====
// ----------------------------------------------------------------------------
// svl_ctrl
// Controller: decodes accepted beats and sequences the in-order readout.
// ----------------------------------------------------------------------------
module svl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            operation,
   input  svl_pkg::dp_stat_type  dp_stat,
   output logic                  busy,
   output svl_pkg::dp_cmd_type   dp_cmd
);

   svl_pkg::state_type                state_ff, state_in;
   logic [svl_pkg::CNT_W-1:0]         remain_ff, remain_in;
   logic                              accept;

   assign busy   = (state_ff == svl_pkg::S_READOUT);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= svl_pkg::S_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         svl_pkg::S_IDLE: begin
            if (accept && operation == svl_pkg::OP_READOUT && dp_stat.count != '0) begin
               state_in = svl_pkg::S_READOUT;
            end
         end
         svl_pkg::S_READOUT: begin
            if (remain_ff == svl_pkg::CNT_W'(1)) begin
               state_in = svl_pkg::S_IDLE;
            end
         end
         default: state_in = svl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.op   = svl_pkg::DP_NONE;
      dp_cmd.last = 1'b1;
      remain_in   = remain_ff;
      unique case (state_ff)
         svl_pkg::S_IDLE: begin
            if (accept) begin
               case (operation)
                  svl_pkg::OP_INSERT: dp_cmd.op = svl_pkg::DP_INSERT;
                  svl_pkg::OP_DELETE: dp_cmd.op = svl_pkg::DP_DELETE;
                  svl_pkg::OP_READOUT: begin
                     if (dp_stat.count == '0) begin
                        dp_cmd.op = svl_pkg::DP_EMPTY;
                     end else begin
                        remain_in = dp_stat.count;
                     end
                  end
                  default: dp_cmd.op = svl_pkg::DP_NONE;
               endcase
            end
         end
         svl_pkg::S_READOUT: begin
            dp_cmd.op   = svl_pkg::DP_ELEMENT;
            dp_cmd.last = (remain_ff == svl_pkg::CNT_W'(1));
            remain_in   = remain_ff - svl_pkg::CNT_W'(1);
         end
         default: dp_cmd.op = svl_pkg::DP_NONE;
      endcase
   end

endmodule

// ===== sv/svl_dpath.sv =====
// ----------------------------------------------------------------------------
// svl_dpath
// Datapath: a row of compare-and-shift cells, the entry count and the
// result register.
// ----------------------------------------------------------------------------
module svl_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [svl_pkg::VAL_W-1:0]  value,
   input  svl_pkg::dp_cmd_type               dp_cmd,
   output svl_pkg::dp_stat_type              dp_stat,
   output logic                              rsp_strobe,
   output svl_pkg::rsp_type                  rsp_data
);

   localparam int N = svl_pkg::CAPACITY;

   logic signed [svl_pkg::VAL_W-1:0] cell_ff [N];
   logic signed [svl_pkg::VAL_W-1:0] ins_in  [N];
   logic signed [svl_pkg::VAL_W-1:0] del_in  [N];
   logic signed [svl_pkg::VAL_W-1:0] rot_in  [N];
   logic [N-1:0]                     valid;
   logic [N-1:0]                     lt;
   logic [N-1:0]                     hit;
   logic                             found;
   logic                             full;
   logic [svl_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                             rsp_strobe_ff;
   svl_pkg::rsp_type                 rsp_ff, rsp_in;

   for (genvar j = 0; j < N; j++) begin : g_cell
      assign valid[j] = (svl_pkg::CNT_W'(j) < count_ff);
      assign lt[j]    = valid[j] && (cell_ff[j] < value);
      if (j == 0) begin : g_first
         assign hit[j]    = valid[j] && !lt[j] && (cell_ff[j] == value);
         assign ins_in[j] = lt[j] ? cell_ff[j] : value;
      end else begin : g_rest
         assign hit[j]    = valid[j] && !lt[j] && lt[j-1] && (cell_ff[j] == value);
         assign ins_in[j] = lt[j] ? cell_ff[j] : (lt[j-1] ? value : cell_ff[j-1]);
      end
      if (j == N - 1) begin : g_top
         assign del_in[j] = cell_ff[j];
         assign rot_in[j] = cell_ff[0];
      end else begin : g_mid
         assign del_in[j] = lt[j] ? cell_ff[j] : cell_ff[j+1];
         assign rot_in[j] = (count_ff == svl_pkg::CNT_W'(j + 1)) ? cell_ff[0] : cell_ff[j+1];
      end
   end

   assign found         = |hit;
   assign full          = (count_ff == svl_pkg::CNT_W'(N));
   assign dp_stat.count = count_ff;

   always_comb begin
      count_in           = count_ff;
      rsp_in.status      = svl_pkg::ST_EMPTY;
      rsp_in.item_value  = '0;
      rsp_in.last        = dp_cmd.last;
      case (dp_cmd.op)
         svl_pkg::DP_INSERT: begin
            if (full) begin
               rsp_in.status = svl_pkg::ST_FULL;
            end else begin
               rsp_in.status = svl_pkg::ST_INSERTED;
               count_in      = count_ff + svl_pkg::CNT_W'(1);
            end
         end
         svl_pkg::DP_DELETE: begin
            if (found) begin
               rsp_in.status = svl_pkg::ST_REMOVED;
               count_in      = count_ff - svl_pkg::CNT_W'(1);
            end else begin
               rsp_in.status = svl_pkg::ST_NOT_FOUND;
            end
         end
         svl_pkg::DP_ELEMENT: begin
            rsp_in.status     = svl_pkg::ST_ELEMENT;
            rsp_in.item_value = cell_ff[0];
         end
         default: rsp_in.status = svl_pkg::ST_EMPTY;
      endcase
      rsp_in.entry_total = 7'(count_in);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < N; j++) begin
         case (dp_cmd.op)
            svl_pkg::DP_INSERT:  if (!full) cell_ff[j] <= ins_in[j];
            svl_pkg::DP_DELETE:  if (found) cell_ff[j] <= del_in[j];
            svl_pkg::DP_ELEMENT: cell_ff[j] <= rot_in[j];
            default:             cell_ff[j] <= cell_ff[j];
         endcase
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= (dp_cmd.op != svl_pkg::DP_NONE);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== sv/sorted_value_list.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list
// Insert and delete take effect at the accepting edge; the single result beat
// follows in the next cycle, and a new command can be taken every cycle.
// A readout of n entries holds busy in the readout state and rotates the cell
// row once, giving n result beats that pass through the state and result
// registers; the next command is taken when busy falls. An empty readout
// gives one beat. Synchronous reset empties the list; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_value_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  svl_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output svl_pkg::rsp_type  rsp_data
);

   svl_pkg::dp_cmd_type  dp_cmd;
   svl_pkg::dp_stat_type dp_stat;

   svl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .dp_stat   (dp_stat),
      .busy      (busy),
      .dp_cmd    (dp_cmd)
   );

   svl_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_data.value),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.entry_total <= 7'(svl_pkg::CAPACITY)))
      else $error("entry total exceeds capacity");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == svl_pkg::OP_INSERT ||
                          req_data.operation == svl_pkg::OP_DELETE))
      |=> (rsp_strobe && rsp_data.last))
      else $error("insert or delete did not give one final beat");

   a_element_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == svl_pkg::ST_ELEMENT) |-> $past(busy))
      else $error("element beat outside a readout");

   a_readout_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_data.last))
      else $error("readout ended without a final beat");

endmodule

// ===== dv/svl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svl_checker
// Watches the command and result channels of the sorted value list, keeps its
// own ordered copy of the stored values, and compares every result beat
// field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module svl_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  svl_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  svl_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               command_count,
   output int               beat_count,
   output int               full_count
);

   logic signed [svl_pkg::VAL_W-1:0] ordered_vals [svl_pkg::CAPACITY];
   int                               held;
   svl_pkg::rsp_type                 expected_rsps [$];
   int                               errors;
   int                               commands;
   int                               beats;
   int                               fulls;

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("[%0t] mismatch on beat %0d: %s got %h, expected %h",
               $realtime, beats, field, got, want);
      errors++;
   endtask

   task automatic apply_command(input svl_pkg::req_type cmd);
      logic signed [svl_pkg::VAL_W-1:0] v;
      svl_pkg::rsp_type                 r;
      int                               pos;
      int                               j;
      v      = cmd.value;
      r      = '0;
      r.last = 1'b1;
      pos    = 0;
      case (cmd.operation)
         svl_pkg::OP_INSERT: begin
            if (held >= svl_pkg::CAPACITY) begin
               r.status = svl_pkg::ST_FULL;
            end else begin
               while (pos < held && ordered_vals[pos] < v) pos++;
               for (j = held; j > pos; j--) ordered_vals[j] = ordered_vals[j-1];
               ordered_vals[pos] = v;
               held++;
               r.status = svl_pkg::ST_INSERTED;
            end
            r.entry_total = 7'(held);
            expected_rsps.push_back(r);
         end
         svl_pkg::OP_DELETE: begin
            while (pos < held && ordered_vals[pos] < v) pos++;
            if (pos >= held || ordered_vals[pos] != v) begin
               r.status = svl_pkg::ST_NOT_FOUND;
            end else begin
               for (j = pos; j + 1 < held; j++) ordered_vals[j] = ordered_vals[j+1];
               held--;
               r.status = svl_pkg::ST_REMOVED;
            end
            r.entry_total = 7'(held);
            expected_rsps.push_back(r);
         end
         svl_pkg::OP_READOUT: begin
            r.entry_total = 7'(held);
            if (held == 0) begin
               r.status = svl_pkg::ST_EMPTY;
               expected_rsps.push_back(r);
            end else begin
               for (j = 0; j < held; j++) begin
                  r.status     = svl_pkg::ST_ELEMENT;
                  r.item_value = ordered_vals[j];
                  r.last       = (j == held - 1);
                  expected_rsps.push_back(r);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      svl_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            apply_command(req_data);
            commands++;
         end
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $display("[%0t] result beat %0d arrived with nothing expected",
                        $realtime, beats);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.item_value !== want.item_value)
                  flag_mismatch("item_value", rsp_data.item_value, want.item_value);
               if (rsp_data.last !== want.last)
                  flag_mismatch("last", 32'(rsp_data.last), 32'(want.last));
               if (rsp_data.entry_total !== want.entry_total)
                  flag_mismatch("entry_total", 32'(rsp_data.entry_total),
                                32'(want.entry_total));
            end
            if (rsp_data.status === svl_pkg::ST_FULL) fulls++;
            beats++;
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_rsps.size();
      command_count  <= commands;
      beat_count     <= beats;
      full_count     <= fulls;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the sorted value list with directed corner commands, a fill to
// capacity with rejected inserts, and random command mixes under varying
// sender idling; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         CYCLE_CAP  = 200000;
   localparam int         MIX_ITEMS  = 25;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   svl_pkg::req_type req_data;
   logic             rsp_strobe;
   svl_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int command_count;
   int beat_count;
   int full_count;
   int cycle_count;
   int idle_pct;

   sorted_value_list dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   svl_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .command_count  (command_count),
      .beat_count     (beat_count),
      .full_count     (full_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] op, input logic [31:0] v);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_data.operation <= op;
      req_data.value     <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 32'($urandom_range(0, 15)) - 32'd8;
      if (sel < 80) begin
         case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h8000_0001;
            2:       return 32'h7fff_ffff;
            3:       return 32'h7fff_fffe;
            4:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [1:0] pick_op();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return svl_pkg::OP_INSERT;
      if (sel < 80) return svl_pkg::OP_DELETE;
      if (sel < 92) return svl_pkg::OP_READOUT;
      return OP_UNUSED;
   endfunction

   initial begin
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(svl_pkg::OP_READOUT, 32'h1234_5678);
      send_beat(svl_pkg::OP_DELETE,  32'h0000_0005);
      send_beat(OP_UNUSED,           32'h0000_0003);
      send_beat(svl_pkg::OP_INSERT,  32'h7fff_ffff);
      send_beat(svl_pkg::OP_INSERT,  32'h8000_0000);
      send_beat(svl_pkg::OP_INSERT,  32'h0000_0000);
      send_beat(svl_pkg::OP_INSERT,  32'hffff_ffff);
      send_beat(svl_pkg::OP_INSERT,  32'h0000_0000);
      send_beat(svl_pkg::OP_INSERT,  32'h0000_0001);
      send_beat(svl_pkg::OP_READOUT, 32'hffff_ffff);
      send_beat(svl_pkg::OP_DELETE,  32'h0000_0002);
      send_beat(svl_pkg::OP_DELETE,  32'h0000_0000);
      send_beat(svl_pkg::OP_DELETE,  32'h8000_0000);
      send_beat(svl_pkg::OP_DELETE,  32'h7fff_ffff);
      send_beat(svl_pkg::OP_READOUT, 32'h0000_0000);
      send_beat(OP_UNUSED,           32'hffff_ffff);
      send_beat(svl_pkg::OP_DELETE,  32'h0000_0000);
      send_beat(svl_pkg::OP_DELETE,  32'hffff_ffff);
      send_beat(svl_pkg::OP_DELETE,  32'h0000_0001);
      send_beat(svl_pkg::OP_READOUT, 32'h0000_0000);
      send_beat(svl_pkg::OP_INSERT,  32'h5555_5555);
      send_beat(svl_pkg::OP_INSERT,  32'haaaa_aaaa);
      send_beat(svl_pkg::OP_READOUT, 32'h0000_0000);

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 7 : (ph == 1) ? 61 : 0;
         if (ph == 1) begin
            // Enough inserts to overflow from any starting count.
            for (int k = 0; k < svl_pkg::CAPACITY + 2; k++) begin
               send_beat(svl_pkg::OP_INSERT, pick_value());
            end
            send_beat(svl_pkg::OP_READOUT, pick_value());
         end
         for (int k = 0; k < MIX_ITEMS; k++) send_beat(pick_op(), pick_value());
      end

      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (svl_pkg::CAPACITY + 8) @(posedge clock);

      $display("Covered %0d commands and %0d result beats, %0d of them full rejections.",
               command_count, beat_count, full_count);
      $display("Sender idling ran at 7, 61 and 0 percent across the random phases.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sorted_value_list.f =====
sv/svl_pkg.sv
sv/svl_ctrl.sv
sv/svl_dpath.sv
sv/sorted_value_list.sv
dv/svl_checker.sv
dv/tb.sv
